// ----- design/ssp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stack sortability checker package
// Value width, value type and the reset value of the expected-value counter.
// ---------------------------------------------------------------------------
package ssp_pkg;

	localparam int VAL_W = 11;

	typedef logic [VAL_W-1:0] val_t;

	localparam val_t EXP_RESET = val_t'(1);

endpackage
`default_nettype wire

// ----- design/ssp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ssp_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/stack_sortable_permutation_check_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stack sortable permutation check unit
// Streams a sequence through one holding stack and reports at the end of the
// sequence whether it could leave in ascending order.
// ---------------------------------------------------------------------------
// The input channel carries one word per sequence value (value, last). The
// output channel carries one word per sequence (sortable, stranded), sent
// after the word marked last has been processed and the stack drained.
// A pushed word or a consumed word whose successor is not on the stack top
// is finished as it is accepted. A consumed word that starts a drain pops
// the top as it is accepted and then reads each further stack entry from
// the single read port of the stack RAM, whether that entry is popped or is
// the one that ends the drain. Each value is pushed and popped at most once.
// The result word is valid from the clock edge that ends the processing of
// the word marked last, and the input is free again at that same edge. A
// waiting result does not block the input; only a second result that finds
// the output register still occupied holds the input stalled until the
// receiver takes the first one. Reset empties the stack and sets the expected
// value to one; the RAM contents need no clearing, since only entries below
// the current depth are read.
// ---------------------------------------------------------------------------
module stack_sortable_permutation_check_unit #(
	parameter int MAX_ITEMS = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  ssp_pkg::val_t value,
	input  wire                last,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               sortable,
	output ssp_pkg::val_t      stranded
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int DW = $clog2(MAX_ITEMS + 1);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_ITEMS);
	localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);
	localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_HOLD  = 2'd2;

	logic [1:0]    state_q, state_d;
	logic [DW-1:0] depth_q, depth_d, depth_dec;
	ssp_pkg::val_t exp_q, exp_d, exp_inc, exp_inc2;
	ssp_pkg::val_t top_q, top_d;
	logic          last_q, last_d, lastv;
	logic          out_valid_q, sortable_q;
	ssp_pkg::val_t stranded_q;
	logic          accept, fin, load, out_free;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	ssp_pkg::val_t ram_rdata;

	ssp_ram #(
		.WIDTH (ssp_pkg::VAL_W),
		.DEPTH (MAX_ITEMS)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign exp_inc   = exp_q + ssp_pkg::val_t'(1);
	assign exp_inc2  = exp_q + ssp_pkg::val_t'(2);
	assign depth_dec = depth_q - DEPTH_ONE;
	assign ram_waddr = depth_q[AW-1:0];
	assign ram_raddr = AW'(depth_q - DEPTH_TWO);

	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		exp_d   = exp_q;
		top_d   = top_q;
		last_d  = last_q;
		lastv   = last_q;
		fin     = 1'b0;
		load    = 1'b0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					last_d = last;
					lastv  = last;
					if (value == exp_q) begin
						if ((depth_q != '0) && (top_q == exp_inc)) begin
							depth_d = depth_dec;
							exp_d   = exp_inc2;
							if (depth_dec != '0) begin
								ram_re  = 1'b1;
								state_d = ST_DRAIN;
							end else begin
								fin = 1'b1;
							end
						end else begin
							exp_d = exp_inc;
							fin   = 1'b1;
						end
					end else if (depth_q != DEPTH_FULL) begin
						ram_we  = 1'b1;
						top_d   = value;
						depth_d = depth_q + DEPTH_ONE;
						fin     = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (ram_rdata == exp_q) begin
					depth_d = depth_dec;
					exp_d   = exp_inc;
					if (depth_dec != '0) begin
						ram_re = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end else begin
					top_d = ram_rdata;
					fin   = 1'b1;
				end
			end
			ST_HOLD: begin
				lastv = 1'b1;
				fin   = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			if (lastv) begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end else begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			exp_q       <= ssp_pkg::EXP_RESET;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			if (load) begin
				depth_q     <= '0;
				exp_q       <= ssp_pkg::EXP_RESET;
				out_valid_q <= 1'b1;
			end else begin
				depth_q     <= depth_d;
				exp_q       <= exp_d;
				out_valid_q <= out_valid_q && out_stall;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (load) begin
			sortable_q <= (depth_d == '0);
			stranded_q <= ssp_pkg::val_t'(depth_d);
		end
	end

	assign out_valid = out_valid_q;
	assign sortable  = sortable_q;
	assign stranded  = stranded_q;

endmodule
`default_nettype wire

// ----- design/ssp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stack sortability checker assertions
// Port-level checks on the check unit, attached to it by a bind statement.
// ---------------------------------------------------------------------------
module ssp_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_stall,
	input wire ssp_pkg::val_t value,
	input wire                last,
	input wire                out_valid,
	input wire                out_stall,
	input wire                sortable,
	input wire ssp_pkg::val_t stranded
);

	// A stalled input word is held by the sender until taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(value) && $stable(last))
		else $error("input word changed while stalled");

	// A stalled result word holds its value until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sortable) && $stable(stranded))
		else $error("result word changed while stalled");

	// A sortable sequence leaves nothing on the stack.
	a_sortable_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sortable |-> stranded == '0)
		else $error("sortable result reports stranded values");

	// A word not marked last never causes a result right after it.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last |=> !$rose(out_valid))
		else $error("result produced without a last word");

	// After a new result appears the input is not held stalled by it.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input stalled while loading a result");

endmodule

bind stack_sortable_permutation_check_unit ssp_checker u_ssp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.value     (value),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.sortable  (sortable),
	.stranded  (stranded)
);
`default_nettype wire

// ----- test/tb_stack_sortable_permutation_check_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stack sortable permutation check unit testbench
// Streams directed and random sequences into the checker with random gaps
// and receiver stalls. A stack tracker in the bench predicts the report for
// each sequence, and every report word is checked against it in order.
// ---------------------------------------------------------------------------
module tb_stack_sortable_permutation_check_unit;

	typedef ssp_pkg::val_t val_t;

	localparam int MAX_ITEMS = 1024;
	localparam int RANDOM_WORDS = 450;
	localparam int TAIL_WORDS = 150;

	typedef struct packed {
		logic sortable;
		val_t stranded;
	} sort_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	wire in_stall;
	val_t value = '0;
	logic last = 1'b0;
	wire out_valid;
	logic out_stall = 1'b0;
	wire sortable;
	wire val_t stranded;

	val_t held[MAX_ITEMS];
	int held_depth = 0;
	val_t next_due = ssp_pkg::EXP_RESET;
	sort_report_t reports_due[$];

	int idle_odds = 20;
	int stall_left = 0;
	int words_sent = 0;
	int error_count = 0;

	stack_sortable_permutation_check_unit #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sortable(sortable),
		.stranded(stranded)
	);

	always #5 clk = ~clk;

	function void drain_held();
		while (held_depth > 0 && held[held_depth - 1] == next_due) begin
			held_depth--;
			next_due++;
		end
	endfunction

	function void predict_sort_outcome(val_t v, logic l);
		sort_report_t rep;
		if (v == next_due) begin
			next_due++;
			drain_held();
		end else if (held_depth < MAX_ITEMS) begin
			held[held_depth] = v;
			held_depth++;
		end
		if (l) begin
			drain_held();
			rep.sortable = (held_depth == 0);
			rep.stranded = val_t'(held_depth);
			reports_due.insert(reports_due.size(), rep);
			held_depth = 0;
			next_due = ssp_pkg::EXP_RESET;
		end
	endfunction

	task automatic send_word(input val_t v, input logic l);
		if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= l;
		do @(posedge clk); while (in_stall);
		predict_sort_outcome(v, l);
		words_sent++;
	endtask

	task automatic send_sequence(input val_t seq[$]);
		foreach (seq[i])
			send_word(seq[i], i == seq.size() - 1);
	endtask

	// Each pop of a random push/pop walk emits the next value in order; the
	// popped entry's push slot takes that value, so the input always sorts.
	task automatic make_sortable(input int n, output val_t seq[$]);
		int open_pos[$];
		int pushed;
		int served;
		pushed = 0;
		served = 1;
		seq = {};
		while (pushed < n || open_pos.size() != 0) begin
			if (open_pos.size() == 0 || (pushed < n && $urandom_range(0, 1) == 1)) begin
				seq.insert(seq.size(), val_t'(0));
				open_pos.insert(open_pos.size(), pushed);
				pushed++;
			end else begin
				seq[open_pos.pop_back()] = val_t'(served);
				served++;
			end
		end
	endtask

	task automatic make_shuffled(input int n, output val_t seq[$]);
		int j;
		val_t tmp;
		seq = {};
		for (int i = 1; i <= n; i++)
			seq.insert(seq.size(), val_t'(i));
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = seq[i];
			seq[i] = seq[j];
			seq[j] = tmp;
		end
	endtask

	task automatic make_noise(input int n, output val_t seq[$]);
		seq = {};
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1) == 1)
				seq.insert(seq.size(), val_t'($urandom_range(0, 2047)));
			else
				seq.insert(seq.size(), val_t'($urandom_range(0, n + 1)));
		end
	endtask

	task automatic send_mixed_sequence();
		val_t seq[$];
		int n;
		int pick;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
		pick = $urandom_range(0, 9);
		if (pick < 6)
			make_sortable(n, seq);
		else if (pick < 8)
			make_shuffled(n, seq);
		else
			make_noise(n, seq);
		send_sequence(seq);
	endtask

	task automatic test_corner_values();
		val_t seq[$];
		seq = {val_t'(1)};
		send_sequence(seq);
		seq = {val_t'(5)};
		send_sequence(seq);
		seq = {val_t'(0)};
		send_sequence(seq);
		seq = {val_t'(2047)};
		send_sequence(seq);
		seq = {val_t'(1024)};
		send_sequence(seq);
		seq = {val_t'(2), val_t'(1)};
		send_sequence(seq);
		seq = {val_t'(3), val_t'(1), val_t'(2)};
		send_sequence(seq);
		seq = {val_t'(2), val_t'(3), val_t'(1)};
		send_sequence(seq);
		seq = {val_t'(1), val_t'(1), val_t'(2)};
		send_sequence(seq);
		seq = {val_t'(1), val_t'(2), val_t'(3), val_t'(4)};
		send_sequence(seq);
		seq = {val_t'(4), val_t'(3), val_t'(2), val_t'(1)};
		send_sequence(seq);
	endtask

	// The word after a full stack must be dropped, or it would block the drain.
	task automatic test_stack_full();
		val_t seq[$];
		seq = {};
		for (int v = MAX_ITEMS + 1; v >= 2; v--)
			seq.insert(seq.size(), val_t'(v));
		seq.insert(seq.size(), val_t'(2047));
		seq.insert(seq.size(), val_t'(1));
		send_sequence(seq);
	endtask

	task automatic test_random_sequences();
		int stop_at;
		int count;
		stop_at = words_sent + RANDOM_WORDS;
		count = 0;
		while (words_sent < stop_at) begin
			if (count % 30 == 0)
				case ($urandom_range(0, 2))
					0: idle_odds = 0;
					1: idle_odds = 15;
					default: idle_odds = 45;
				endcase
			send_mixed_sequence();
			count++;
		end
	endtask

	task automatic test_quiet_tail();
		int stop_at;
		idle_odds = 0;
		stop_at = words_sent + TAIL_WORDS;
		while (words_sent < stop_at)
			send_mixed_sequence();
	endtask

	always @(posedge clk) begin : report_check
		sort_report_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("Unexpected word: sortable=%0d stranded=%0d",
							sortable, stranded);
				end else begin
					due = reports_due[0];
					reports_due.delete(0);
					if (sortable !== due.sortable || stranded !== due.stranded) begin
						error_count++;
						if (error_count <= 10)
							$display("Mismatch: expected %0d/%0d, got %0d/%0d",
								due.sortable, due.stranded, sortable, stranded);
					end
				end
			end
			if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, 100) <= idle_odds / 2)
				stall_left = $urandom_range(1, 5);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_corner_values();
		test_stack_full();
		test_random_sequences();
		test_quiet_tail();
		in_valid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

endmodule
